### design/grid_ray_march_column_assert.svh
// ----------------------------------------------------------------------------
// grid_ray_march_column assertion macros
// shared property forms for the column raycaster checks
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_MARCH_COLUMN_ASSERT_SVH
`define GRID_RAY_MARCH_COLUMN_ASSERT_SVH

// same-cycle implication
`define GRMC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grmc check failed");

// next-cycle implication
`define GRMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grmc check failed");

`endif

### design/grmc_pkg.sv
// ----------------------------------------------------------------------------
// grmc_pkg
// constants, types and helpers of the column raycaster
// ----------------------------------------------------------------------------
package grmc_pkg;

	localparam int MAP_SIDE       = 64;
	localparam int MAP_BITS       = $clog2(MAP_SIDE);
	localparam int ADDR_W         = 2 * MAP_BITS;
	localparam int ANGLE_BITS     = 12;
	localparam int ANG_SHIFT      = 32 - ANGLE_BITS;
	localparam int MAX_DISTANCE   = 15;
	localparam int STEPS_PER_UNIT = 200;
	localparam int STEPS          = MAX_DISTANCE * STEPS_PER_UNIT;
	localparam int K_W            = $clog2(STEPS + 1);

	// ray point, Q.16 signed
	localparam int POS_W  = 25;
	localparam int CELL_W = POS_W - 16;

	// divider operand widths
	localparam int DIVN_W = 41;
	localparam int DIVD_W = 29;

	localparam logic [28:0] FOV_TURN  = 29'd451153082;
	localparam logic [31:0] HALF_FOV  = 32'(FOV_TURN / 2);
	localparam logic [31:0] QUARTER   = 32'h4000_0000;

	// floor(a/200) = (a * SPLIT_RECIP) >> 24 for a <= 2^16
	localparam logic [16:0] SPLIT_RECIP = 17'd83887;
	// floor(k*4096/200) = (k * DIST_RECIP) >> 18 for k <= STEPS
	localparam logic [22:0] DIST_RECIP  = 23'd5368710;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] SC1 = 17'd102944;
	localparam logic [16:0] SC3 = 17'd42334;
	localparam logic [16:0] SC5 = 17'd5223;
	localparam logic [16:0] SC7 = 17'd307;
	localparam logic [16:0] SC9 = 17'd11;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_TEXTURE_WIDTH = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REL_MUL,
		ST_REL_DIV_GO,
		ST_REL_DIV_WAIT,
		ST_TRIG_C_GO,
		ST_TRIG_C_WAIT,
		ST_TRIG_S_GO,
		ST_TRIG_S_WAIT,
		ST_SPLIT1,
		ST_SPLIT2,
		ST_MARCH,
		ST_DIST,
		ST_TRIG_R_GO,
		ST_TRIG_R_WAIT,
		ST_LH_MUL,
		ST_LH_DIV_GO,
		ST_LH_DIV_WAIT,
		ST_FINISH
	} grmc_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic              data;
	} map_wr_t;

	// polynomial coefficient used at each step of the sine sequence
	function automatic logic [16:0] sin_coef(input logic [2:0] idx);
		logic [16:0] c;
		case (idx)
			3'd2:    c = SC7;
			3'd3:    c = SC5;
			3'd4:    c = SC3;
			3'd5:    c = SC1;
			default: c = SC9;
		endcase
		return c;
	endfunction

endpackage

### design/grmc_map_ram.sv
// ----------------------------------------------------------------------------
// grmc_map_ram
// wall map, one bit per cell, one write and one registered read port
// ----------------------------------------------------------------------------
module grmc_map_ram import grmc_pkg::*; (
	input  logic              clk,
	input  map_wr_t           wr,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic              rd_data
);

	logic mem [2**ADDR_W];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### design/grmc_divider.sv
// ----------------------------------------------------------------------------
// grmc_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grmc_divider import grmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] dividend,
	input  logic [DIVD_W-1:0] divisor,
	output logic              done,
	output logic [DIVN_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVN_W);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] dsr_q;
	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIVN_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIVN_W - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? DIVD_W'(trial - {1'b0, dsr_q}) : trial[DIVD_W-1:0];
			quo_q <= {quo_q[DIVN_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/grmc_trig.sv
// ----------------------------------------------------------------------------
// grmc_trig
// Q16 sine of a Q32 turn, odd polynomial on one shared multiplier
// ----------------------------------------------------------------------------
module grmc_trig import grmc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        turn,
	output logic               done,
	output logic signed [17:0] value
);

	logic               run_q;
	logic               done_q;
	logic [2:0]         idx_q;
	logic [16:0]        x_q;
	logic [16:0]        x2_q;
	logic [33:0]        prod_q;
	logic               neg_q;
	logic signed [17:0] val_q;
	logic [16:0]        x_in;
	logic [16:0]        p;
	logic [17:0]        s;
	logic [17:0]        s_sat;

	// fold odd quadrants onto the rising quarter
	assign x_in  = turn[30] ? (ONE_Q16 - {1'b0, turn[29:14]}) : {1'b0, turn[29:14]};
	assign p     = 17'({1'b0, sin_coef(idx_q)} - prod_q[33:16]);
	assign s     = prod_q[33:16];
	assign s_sat = (s > 18'(ONE_Q16)) ? 18'(ONE_Q16) : s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				idx_q <= 3'd1;
			end else if (run_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == 3'd6) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x_in;
			neg_q  <= turn[31];
			prod_q <= 34'(x_in) * 34'(x_in);
		end else if (run_q) begin
			case (idx_q) inside
				3'd1: begin
					x2_q   <= prod_q[32:16];
					prod_q <= 34'(prod_q[32:16]) * 34'(SC9);
				end
				3'd2, 3'd3, 3'd4: prod_q <= 34'(x2_q) * 34'(p);
				3'd5:             prod_q <= 34'(x_q) * 34'(p);
				3'd6:             val_q  <= neg_q ? -$signed(s_sat) : $signed(s_sat);
				default: ;
			endcase
		end
	end

	assign done  = done_q;
	assign value = val_q;

endmodule

### design/grid_ray_march_column.sv
// ----------------------------------------------------------------------------
// grid_ray_march_column
// column raycaster: fixed-step ray march over a 64 x 64 one-bit wall map
// ----------------------------------------------------------------------------
// After reset the block sweeps the wall map clear, one cell a cycle, and
// holds busy during the sweep; configuration writes are taken during the
// sweep. A map write item is taken while idle and leaves busy low. A cast
// item keeps busy high through two 41-step divisions (ray offset, line
// height), three sine sequences on one shared multiplier and the march,
// which takes one map cell per cycle through the map memory's registered
// read port. A miss ends after the march, without the third sine sequence
// and the second division; a hit skips the second division when the slice
// height saturates (hit at step zero or a corrected cosine that is not
// positive). Each cast gives exactly one result, shown for one cycle with
// result_valid high in the same cycle that busy drops; there is no way to
// hold it off, so the receiver must take it in that cycle.
// ----------------------------------------------------------------------------
module grid_ray_march_column import grmc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// item transfer
	input  logic               start,
	output logic               busy,
	input  logic               req_type,
	input  logic [11:0]        column,
	input  logic [15:0]        viewer_x,
	input  logic [15:0]        viewer_y,
	input  logic [11:0]        viewer_angle,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_y,
	input  logic               cell_wall,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [12:0]        cfg_data,
	// result
	output logic               result_valid,
	output logic [11:0]        column_out,
	output logic               hit,
	output logic [15:0]        hit_distance,
	output logic [15:0]        slice_height,
	output logic signed [15:0] top_row,
	output logic [9:0]         texture_column
);

	localparam logic [K_W-1:0] K_LAST = K_W'(STEPS - 1);

	grmc_state_t state_q, state_d;

	// configuration
	logic [12:0] sw_q, sh_q;
	logic [10:0] tw_q;

	// captured cast item
	logic [11:0] col_q;
	logic [15:0] vx_q, vy_q;
	logic [11:0] ang_q;

	// ray setup
	logic [DIVN_W-1:0]  prod_rel_q;
	logic [31:0]        rel_q;
	logic signed [17:0] c_q, s_q, crel_q;
	logic [9:0]         qx_s1, qy_s1;
	logic signed [9:0]  cqx_q, cqy_q;
	logic [7:0]         crx_q, cry_q;

	// march pipeline: point k issued to the map, its cell back in the next cycle
	logic                    issue_q;
	logic signed [POS_W-1:0] px_q, py_q;
	logic [7:0]              rx_q, ry_q;
	logic [K_W-1:0]          k_q;
	logic                    v_s1;
	logic signed [POS_W-1:0] px_s1, py_s1;
	logic [K_W-1:0]          k_s1;
	logic                    oob_s1;

	// hit
	logic           found_q;
	logic [15:0]    hx_q, hy_q;
	logic [K_W-1:0] khit_q;
	logic [15:0]    dist_q;
	logic [DIVD_W-1:0] den_q;
	logic [15:0]    lh_q;

	logic [ADDR_W-1:0] clr_cnt_q;

	// result registers
	logic               result_valid_q;
	logic [11:0]        column_out_q;
	logic               hit_q;
	logic [15:0]        hit_distance_q;
	logic [15:0]        slice_height_q;
	logic signed [15:0] top_row_q;
	logic [9:0]         texture_column_q;

	// unit hookups
	logic              div_start, div_done;
	logic [DIVN_W-1:0] div_dividend, div_quot;
	logic [DIVD_W-1:0] div_divisor;
	logic              trig_start, trig_done;
	logic [31:0]       trig_turn, ray;
	logic signed [17:0] trig_val;
	map_wr_t           map_wr;
	logic [ADDR_W-1:0] map_rd_addr;
	logic              map_rd;

	logic accept, cast_accept, wr_accept;
	logic s1_wall, march_stop, lh_special;
	logic [16:0] ax, ay;
	logic [16:0] rx_full, ry_full;
	logic [8:0]  sum_x, sum_y;
	logic        carry_x, carry_y;
	logic [12:0] sw_eff;
	logic        oob_q;
	logic [16:0] tx, ty, tsel;
	logic        sel_y, hneg;
	logic [27:0] tprod;
	logic [11:0] tcol, tex;

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign cast_accept = accept && !req_type;
	assign wr_accept   = accept && req_type;
	assign cfg_ready   = 1'b1;

	// ray angle: view direction plus column offset across the field of view
	assign ray = (32'(ang_q) << ANG_SHIFT) + rel_q;

	// zero screen width acts as one
	assign sw_eff = (sw_q == '0) ? 13'd1 : sw_q;

	// direction magnitudes for the per-step split into step/200 parts
	assign ax = c_q[17] ? 17'(-c_q) : 17'(c_q);
	assign ay = s_q[17] ? 17'(-s_q) : 17'(s_q);
	assign rx_full = ax - 17'(qx_s1) * 17'(STEPS_PER_UNIT);
	assign ry_full = ay - 17'(qy_s1) * 17'(STEPS_PER_UNIT);

	// next point: floor(k*c/200) tracked as quotient plus remainder
	assign sum_x   = 9'(rx_q) + 9'(crx_q);
	assign sum_y   = 9'(ry_q) + 9'(cry_q);
	assign carry_x = sum_x >= 9'(STEPS_PER_UNIT);
	assign carry_y = sum_y >= 9'(STEPS_PER_UNIT);

	// negative coordinate or cell beyond the map reads as wall
	assign oob_q = px_q[POS_W-1] || py_q[POS_W-1]
		|| ({1'b0, px_q[POS_W-2:16]} >= CELL_W'(MAP_SIDE))
		|| ({1'b0, py_q[POS_W-2:16]} >= CELL_W'(MAP_SIDE));

	assign map_rd_addr = {py_q[16+MAP_BITS-1:16], px_q[16+MAP_BITS-1:16]};

	assign s1_wall    = oob_s1 || map_rd;
	assign march_stop = v_s1 && (s1_wall || (k_s1 == K_LAST));
	assign lh_special = (khit_q == '0) || (crel_q <= 18'sd0);

	// texel column from the larger-magnitude hit fraction, x on ties
	assign tx    = hx_q[15] ? (ONE_Q16 - 17'(hx_q)) : 17'(hx_q);
	assign ty    = hy_q[15] ? (ONE_Q16 - 17'(hy_q)) : 17'(hy_q);
	assign sel_y = ty > tx;
	assign tsel  = sel_y ? ty : tx;
	assign hneg  = sel_y ? hy_q[15] : hx_q[15];
	assign tprod = 28'(tsel) * 28'(tw_q);
	assign tcol  = tprod[27:16];
	assign tex   = (hneg && (tcol != '0)) ? (12'(tw_q) - tcol) : tcol;

	// map write port: reset sweep or a map write item
	always_comb begin
		if (state_q == ST_CLEAR) begin
			map_wr.we   = 1'b1;
			map_wr.addr = clr_cnt_q;
			map_wr.data = 1'b0;
		end else begin
			map_wr.we   = wr_accept;
			map_wr.addr = {ADDR_W'(cell_y) << MAP_BITS} | ADDR_W'(cell_x);
			map_wr.data = cell_wall;
		end
	end

	// shared divider operands
	always_comb begin
		if (state_q == ST_LH_DIV_GO) begin
			div_dividend = DIVN_W'(DIVN_W'(DIVN_W'(sh_q) * DIVN_W'(STEPS_PER_UNIT)) << 16);
			div_divisor  = den_q;
		end else begin
			div_dividend = prod_rel_q;
			div_divisor  = DIVD_W'(sw_eff);
		end
	end

	// shared sine unit: cosine is sine a quarter turn on
	always_comb begin
		unique case (state_q)
			ST_TRIG_C_GO: trig_turn = ray + QUARTER;
			ST_TRIG_S_GO: trig_turn = ray;
			default:      trig_turn = rel_q + QUARTER;
		endcase
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		trig_start = 1'b0;
		unique case (state_q)
			ST_CLEAR:        if (clr_cnt_q == '1) state_d = ST_IDLE;
			ST_IDLE:         if (cast_accept) state_d = ST_REL_MUL;
			ST_REL_MUL:      state_d = ST_REL_DIV_GO;
			ST_REL_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_REL_DIV_WAIT;
			end
			ST_REL_DIV_WAIT: if (div_done) state_d = ST_TRIG_C_GO;
			ST_TRIG_C_GO: begin
				trig_start = 1'b1;
				state_d    = ST_TRIG_C_WAIT;
			end
			ST_TRIG_C_WAIT:  if (trig_done) state_d = ST_TRIG_S_GO;
			ST_TRIG_S_GO: begin
				trig_start = 1'b1;
				state_d    = ST_TRIG_S_WAIT;
			end
			ST_TRIG_S_WAIT:  if (trig_done) state_d = ST_SPLIT1;
			ST_SPLIT1:       state_d = ST_SPLIT2;
			ST_SPLIT2:       state_d = ST_MARCH;
			ST_MARCH:        if (march_stop) state_d = ST_DIST;
			ST_DIST:         state_d = found_q ? ST_TRIG_R_GO : ST_FINISH;
			ST_TRIG_R_GO: begin
				trig_start = 1'b1;
				state_d    = ST_TRIG_R_WAIT;
			end
			ST_TRIG_R_WAIT:  if (trig_done) state_d = ST_LH_MUL;
			ST_LH_MUL:       state_d = lh_special ? ST_FINISH : ST_LH_DIV_GO;
			ST_LH_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_LH_DIV_WAIT;
			end
			ST_LH_DIV_WAIT:  if (div_done) state_d = ST_FINISH;
			ST_FINISH:       state_d = ST_IDLE;
			default:         state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_cnt_q      <= '0;
			issue_q        <= 1'b0;
			v_s1           <= 1'b0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
			sw_q           <= 13'd640;
			sh_q           <= 13'd480;
			tw_q           <= 11'd64;
		end else begin
			state_q        <= state_d;
			result_valid_q <= (state_q == ST_FINISH);
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_valid) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  sw_q <= cfg_data;
					REG_SCREEN_HEIGHT: sh_q <= cfg_data;
					REG_TEXTURE_WIDTH: tw_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (cast_accept) begin
				found_q <= 1'b0;
			end
			if (state_q == ST_SPLIT2) begin
				issue_q <= 1'b1;
			end else if (state_q == ST_MARCH) begin
				if (march_stop || (issue_q && (k_q == K_LAST))) begin
					issue_q <= 1'b0;
				end
				if (march_stop) begin
					found_q <= s1_wall;
				end
			end else begin
				issue_q <= 1'b0;
			end
			v_s1 <= (state_q == ST_MARCH) && issue_q && !march_stop;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cast_accept) begin
			col_q <= column;
			vx_q  <= viewer_x;
			vy_q  <= viewer_y;
			ang_q <= viewer_angle;
		end
		case (state_q)
			ST_REL_MUL: prod_rel_q <= DIVN_W'(FOV_TURN) * DIVN_W'(col_q);
			ST_REL_DIV_WAIT: if (div_done) rel_q <= div_quot[31:0] - HALF_FOV;
			ST_TRIG_C_WAIT:  if (trig_done) c_q <= trig_val;
			ST_TRIG_S_WAIT:  if (trig_done) s_q <= trig_val;
			ST_SPLIT1: begin
				qx_s1 <= 10'((34'(ax) * 34'(SPLIT_RECIP)) >> 24);
				qy_s1 <= 10'((34'(ay) * 34'(SPLIT_RECIP)) >> 24);
			end
			ST_SPLIT2: begin
				// floor split of the direction by 200, remainder in [0, 200)
				if (c_q[17]) begin
					cqx_q <= -$signed(10'(qx_s1)) - 10'(rx_full != '0);
					crx_q <= (rx_full != '0) ? 8'(17'(STEPS_PER_UNIT) - rx_full) : 8'd0;
				end else begin
					cqx_q <= $signed(qx_s1);
					crx_q <= rx_full[7:0];
				end
				if (s_q[17]) begin
					cqy_q <= -$signed(10'(qy_s1)) - 10'(ry_full != '0);
					cry_q <= (ry_full != '0) ? 8'(17'(STEPS_PER_UNIT) - ry_full) : 8'd0;
				end else begin
					cqy_q <= $signed(qy_s1);
					cry_q <= ry_full[7:0];
				end
				px_q <= POS_W'({vx_q, 6'b0});
				py_q <= POS_W'({vy_q, 6'b0});
				rx_q <= '0;
				ry_q <= '0;
				k_q  <= '0;
			end
			ST_MARCH: begin
				if (issue_q) begin
					px_s1  <= px_q;
					py_s1  <= py_q;
					k_s1   <= k_q;
					oob_s1 <= oob_q;
					px_q   <= px_q + POS_W'(cqx_q) + POS_W'(carry_x);
					py_q   <= py_q + POS_W'(cqy_q) + POS_W'(carry_y);
					rx_q   <= carry_x ? 8'(sum_x - 9'(STEPS_PER_UNIT)) : sum_x[7:0];
					ry_q   <= carry_y ? 8'(sum_y - 9'(STEPS_PER_UNIT)) : sum_y[7:0];
					k_q    <= k_q + 1'b1;
				end
				if (march_stop) begin
					hx_q   <= px_s1[15:0];
					hy_q   <= py_s1[15:0];
					khit_q <= s1_wall ? k_s1 : K_W'(STEPS);
				end
			end
			ST_DIST: dist_q <= 16'((35'(khit_q) * 35'(DIST_RECIP)) >> 18);
			ST_TRIG_R_WAIT: if (trig_done) crel_q <= trig_val;
			ST_LH_MUL: begin
				den_q <= DIVD_W'(khit_q) * DIVD_W'(crel_q[16:0]);
				lh_q  <= 16'hFFFF;
			end
			ST_LH_DIV_WAIT: begin
				if (div_done) begin
					lh_q <= (div_quot[DIVN_W-1:16] != '0) ? 16'hFFFF : div_quot[15:0];
				end
			end
			ST_FINISH: begin
				column_out_q <= col_q;
				hit_q        <= found_q;
				if (found_q) begin
					hit_distance_q   <= dist_q;
					slice_height_q   <= lh_q;
					top_row_q        <= $signed(16'(sh_q >> 1) - 16'(lh_q >> 1));
					texture_column_q <= tex[9:0];
				end else begin
					hit_distance_q   <= '0;
					slice_height_q   <= '0;
					top_row_q        <= '0;
					texture_column_q <= '0;
				end
			end
			default: ;
		endcase
	end

	grmc_map_ram u_map (
		.clk     (clk),
		.wr      (map_wr),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd)
	);

	grmc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	grmc_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (trig_start),
		.turn   (trig_turn),
		.done   (trig_done),
		.value  (trig_val)
	);

	assign result_valid   = result_valid_q;
	assign column_out     = column_out_q;
	assign hit            = hit_q;
	assign hit_distance   = hit_distance_q;
	assign slice_height   = slice_height_q;
	assign top_row        = top_row_q;
	assign texture_column = texture_column_q;

endmodule

### design/grmc_checker.sv
// ----------------------------------------------------------------------------
// grmc_checker
// port-level checks of the column raycaster, bound to the top level
// ----------------------------------------------------------------------------
`include "grid_ray_march_column_assert.svh"

module grmc_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               req_type,
	input logic               result_valid,
	input logic               hit,
	input logic [15:0]        hit_distance,
	input logic [15:0]        slice_height,
	input logic signed [15:0] top_row,
	input logic [9:0]         texture_column
);

	// every hit-only field reads zero
	logic miss_clear;

	assign miss_clear = (hit_distance == 16'd0) && (slice_height == 16'd0)
		&& (texture_column == 10'd0) && (top_row == 16'sd0);

	`GRMC_ASSERT_NEXT(a_cast_busy, start && !busy && !req_type, busy)
	`GRMC_ASSERT_NEXT(a_write_idle, start && !busy && req_type, !busy)
	`GRMC_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid)
	`GRMC_ASSERT_SAME(a_strobe_after_work, result_valid, $past(busy))
	`GRMC_ASSERT_SAME(a_miss_zero, result_valid && !hit, miss_clear)

endmodule

bind grid_ray_march_column grmc_port_checks u_grmc_port_checks (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.req_type       (req_type),
	.result_valid   (result_valid),
	.hit            (hit),
	.hit_distance   (hit_distance),
	.slice_height   (slice_height),
	.top_row        (top_row),
	.texture_column (texture_column)
);
